// ===== hdl/pdpt_pkg.sv =====
// Shared types, constants and the microcode program of the point-turn controller.
package pdpt_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_TARGET_HEADING  = 3'd0;
	localparam logic [2:0] REG_PROP_GAIN       = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN      = 3'd2;
	localparam logic [2:0] REG_IMU_WEIGHT      = 3'd3;
	localparam logic [2:0] REG_WHEEL_DEG_SCALE = 3'd4;
	localparam logic [2:0] REG_DONE_MARGIN     = 3'd5;

	// Datapath limits.
	localparam logic [16:0] ERR_MAX     = 17'd131071;
	localparam int          DRIVE_SCALE = 25600;
	localparam int          DRIVE_LIM   = 127 * DRIVE_SCALE;
	localparam logic [12:0] RECIP_100   = 13'd5243;

	// Last step of the program.
	localparam logic [3:0] LAST_STEP = 4'd15;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_DELTA,
		OP_MUL_WS,
		OP_MUL_W,
		OP_MUL_IW,
		OP_ADD_IMU,
		OP_ROUND,
		OP_HEAD,
		OP_ERR,
		OP_DECIDE,
		OP_MUL_KP,
		OP_MUL_KD,
		OP_ADD,
		OP_SAT,
		OP_DIV,
		OP_OUT
	} op_t;

	// Jump conditions.
	typedef enum logic [1:0] {
		CND_NONE,
		CND_WAIT_IN,
		CND_NO_PD,
		CND_OUT_BUSY
	} cond_t;

	// One control word.
	typedef struct packed {
		op_t        op;
		cond_t      cond;
		logic [3:0] target;
	} ucode_t;

	// Status fed back to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic no_pd;
	} seq_status_t;

	// Control driven by the sequencer.
	typedef struct packed {
		op_t  op;
		logic idle;
	} seq_ctrl_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [8:0]  target_heading;
		logic [15:0] prop_gain;
		logic [15:0] deriv_gain;
		logic [8:0]  imu_weight;
		logic [15:0] wheel_deg_scale;
		logic [15:0] done_margin;
	} cfg_t;

	// Program store: one tick runs from the idle step to the output step.
	function automatic ucode_t ucode_rom(input logic [3:0] pc);
		ucode_t w;
		begin
			case (pc)
				4'd0:    w = '{OP_NOP,     CND_WAIT_IN,  4'd0};
				4'd1:    w = '{OP_DELTA,   CND_NONE,     4'd0};
				4'd2:    w = '{OP_MUL_WS,  CND_NONE,     4'd0};
				4'd3:    w = '{OP_MUL_W,   CND_NONE,     4'd0};
				4'd4:    w = '{OP_MUL_IW,  CND_NONE,     4'd0};
				4'd5:    w = '{OP_ADD_IMU, CND_NONE,     4'd0};
				4'd6:    w = '{OP_ROUND,   CND_NONE,     4'd0};
				4'd7:    w = '{OP_HEAD,    CND_NONE,     4'd0};
				4'd8:    w = '{OP_ERR,     CND_NONE,     4'd0};
				4'd9:    w = '{OP_DECIDE,  CND_NO_PD,    LAST_STEP};
				4'd10:   w = '{OP_MUL_KP,  CND_NONE,     4'd0};
				4'd11:   w = '{OP_MUL_KD,  CND_NONE,     4'd0};
				4'd12:   w = '{OP_ADD,     CND_NONE,     4'd0};
				4'd13:   w = '{OP_SAT,     CND_NONE,     4'd0};
				4'd14:   w = '{OP_DIV,     CND_NONE,     4'd0};
				4'd15:   w = '{OP_OUT,     CND_OUT_BUSY, LAST_STEP};
				default: w = '{OP_NOP,     CND_NONE,     4'd0};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== hdl/pdpt_seq.sv =====
// Microcode sequencer: step counter, program store and conditional jumps.
module pdpt_seq import pdpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output seq_ctrl_t   ctrl
);

	logic [3:0] pc_q;
	ucode_t     word;
	logic       taken;

	// Fetch the control word and evaluate its jump condition.
	always_comb begin
		word = ucode_rom(pc_q);
		case (word.cond)
			CND_NONE:     taken = 1'b0;
			CND_WAIT_IN:  taken = !status.in_valid;
			CND_NO_PD:    taken = status.no_pd;
			CND_OUT_BUSY: taken = status.out_busy;
			default:      taken = 1'b0;
		endcase
		ctrl.op   = word.op;
		ctrl.idle = (pc_q == 4'd0);
	end

	// Step counter; the output step returns to idle once the result is placed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 4'd0;
		end else if (taken) begin
			pc_q <= word.target;
		end else if (pc_q == LAST_STEP) begin
			pc_q <= 4'd0;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

endmodule

// ===== hdl/pdpt_dp.sv =====
// Datapath: shared multiplier, accumulator, heading state and PD arithmetic.
module pdpt_dp import pdpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  cfg_t               cfg,
	input  logic signed [31:0] horiz_count,
	input  logic        [15:0] imu_heading,
	input  logic               start_req,
	output logic               no_pd,
	output logic signed [7:0]  drive,
	output logic               finished
);

	// Operand and working registers.
	logic signed [32:0] wd_q;
	logic signed [16:0] id_q;
	logic        [8:0]  w_q;
	logic signed [57:0] prod_q;
	logic signed [57:0] acc_q;
	logic signed [34:0] step_q;
	logic        [16:0] err_q;
	logic               diff_pos_q;
	logic signed [17:0] derr_q;
	logic        [13:0] t_q;
	logic               neg_q;
	logic signed [7:0]  drive_q;

	// Turn state.
	logic signed [31:0] heading_q;
	logic signed [31:0] last_wheel_q;
	logic        [15:0] last_imu_q;
	logic        [16:0] last_err_q;
	logic               sign_q;
	logic               finished_q;

	// Shared multiplier.
	logic signed [47:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [57:0] mul_r;

	// Combinational results used by the datapath steps.
	logic        [9:0]  w_inv;
	logic               acc_neg;
	logic        [57:0] acc_mag;
	logic        [33:0] round_q;
	logic signed [35:0] h_sum;
	logic signed [31:0] h_sat;
	logic signed [9:0]  tw;
	logic signed [16:0] tgt100;
	logic signed [33:0] diff;
	logic        [33:0] diff_mag;
	logic        [16:0] err_c;
	logic               in_margin;
	logic signed [34:0] num;
	logic signed [34:0] num_sat;
	logic        [21:0] num_mag;
	logic        [22:0] num_rnd;
	logic        [26:0] div_p;
	logic        [6:0]  q7;

	assign w_inv = 10'd256 - {1'b0, w_q};

	// Operand selection for the multiplier.
	always_comb begin
		case (op)
			OP_MUL_WS: begin
				mul_a = 48'(wd_q);
				mul_b = 18'($signed(cfg.wheel_deg_scale));
			end
			OP_MUL_W: begin
				mul_a = prod_q[47:0];
				mul_b = $signed({8'd0, w_inv});
			end
			OP_MUL_IW: begin
				mul_a = 48'(id_q);
				mul_b = $signed({9'd0, w_q});
			end
			OP_MUL_KP: begin
				mul_a = $signed({31'd0, err_q});
				mul_b = $signed({2'd0, cfg.prop_gain});
			end
			OP_MUL_KD: begin
				mul_a = 48'(derr_q);
				mul_b = $signed({2'd0, cfg.deriv_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
		mul_r = mul_p[57:0];
	end

	// Heading step rounding, heading saturation and error.
	always_comb begin
		acc_neg  = acc_q[57];
		acc_mag  = acc_neg ? 58'(-acc_q) : 58'(acc_q);
		round_q  = 34'((acc_mag + 58'd8388608) >> 24);

		h_sum = 36'(heading_q) + 36'(step_q);
		if (h_sum > 36'sd2147483647) begin
			h_sat = 32'sh7FFFFFFF;
		end else if (h_sum < -36'sd2147483648) begin
			h_sat = 32'sh80000000;
		end else begin
			h_sat = h_sum[31:0];
		end

		// Wrap the target into (-180,180] degrees.
		tw = 10'($signed(cfg.target_heading));
		if (tw <= -10'sd180) begin
			tw = tw + 10'sd360;
		end else if (tw > 10'sd180) begin
			tw = tw - 10'sd360;
		end
		tgt100 = (17'(tw) <<< 6) + (17'(tw) <<< 5) + (17'(tw) <<< 2);
		diff     = 34'(tgt100) - 34'(heading_q);
		diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
		err_c    = (diff_mag > 34'(ERR_MAX)) ? ERR_MAX : diff_mag[16:0];

		in_margin = (err_q <= {1'b0, cfg.done_margin});
		no_pd     = start_req || finished_q || in_margin;
	end

	// Drive saturation and scaling by 1/25600.
	always_comb begin
		num = acc_q[34:0];
		if (num > 35'sd3251200) begin
			num_sat = 35'sd3251200;
		end else if (num < -35'sd3251200) begin
			num_sat = -35'sd3251200;
		end else begin
			num_sat = num;
		end
		num_mag = num_sat[34] ? 22'(-num_sat) : 22'(num_sat);
		num_rnd = {1'b0, num_mag} + 23'd12800;
		div_p   = 27'(t_q) * 27'(RECIP_100);
		q7      = div_p[25:19];
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (op)
			OP_DELTA: begin
				wd_q <= 33'(horiz_count) - 33'(last_wheel_q);
				id_q <= $signed({1'b0, imu_heading}) - $signed({1'b0, last_imu_q});
				w_q  <= (cfg.imu_weight > 9'd256) ? 9'd256 : cfg.imu_weight;
			end
			OP_MUL_WS, OP_MUL_IW, OP_MUL_KD: prod_q <= mul_r;
			OP_MUL_W, OP_MUL_KP:             acc_q  <= mul_r;
			OP_ADD_IMU: acc_q <= acc_q + (prod_q <<< 16);
			OP_ADD:     acc_q <= acc_q + prod_q;
			OP_ROUND:   step_q <= acc_neg ? -$signed({1'b0, round_q}) : $signed({1'b0, round_q});
			OP_ERR: begin
				err_q      <= err_c;
				diff_pos_q <= (diff > 34'sd0);
			end
			OP_DECIDE: begin
				derr_q  <= $signed({1'b0, err_q}) - $signed({1'b0, last_err_q});
				drive_q <= '0;
			end
			OP_SAT: begin
				t_q   <= num_rnd[21:8];
				neg_q <= num_sat[34] ^ sign_q;
			end
			OP_DIV: drive_q <= neg_q ? -$signed({1'b0, q7}) : $signed({1'b0, q7});
			default: ;
		endcase
	end

	// Heading and turn state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q    <= '0;
			last_wheel_q <= '0;
			last_imu_q   <= '0;
			last_err_q   <= '0;
			sign_q       <= 1'b0;
			finished_q   <= 1'b1;
		end else begin
			case (op)
				OP_HEAD: begin
					heading_q    <= h_sat;
					last_wheel_q <= horiz_count;
					last_imu_q   <= imu_heading;
				end
				OP_DECIDE: begin
					if (start_req) begin
						last_err_q <= err_q;
						sign_q     <= !diff_pos_q;
						finished_q <= (err_q == 17'd0) || in_margin;
					end else if (!finished_q) begin
						last_err_q <= err_q;
						if (in_margin) begin
							finished_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign drive    = drive_q;
	assign finished = finished_q;

endmodule

// ===== hdl/odometry_pd_point_turn.sv =====
// Top level: configuration registers, request capture, result register and sequencer.
// An accepted request runs through the microcode program up to the output step, which
// loads the result; the PD steps are skipped when the turn is starting or finished.
// Requests are taken one at a time: a new one is accepted only when the sequencer, which
// steps the shared multiplier through the program, is idle; a result waiting downstream stalls the last step.
// Reset (arst_n low): configuration to its defaults, heading and history cleared,
// turn marked finished, no result pending.
module odometry_pd_point_turn import pdpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // horiz_count[31:0], imu_heading[47:32]
	input  logic        s_tuser,  // start_req
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // left_drive[7:0], right_drive[15:8]
	output logic        m_tuser   // done_res
);

	cfg_t               cfg_q;
	logic signed [31:0] count_q;
	logic        [15:0] imu_q;
	logic               start_q;
	logic               m_tvalid_q;
	logic        [15:0] m_tdata_q;
	logic               m_tuser_q;

	seq_status_t        status;
	seq_ctrl_t          ctrl;
	logic               no_pd;
	logic signed [7:0]  drive;
	logic               finished;
	logic signed [7:0]  right;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_heading  <= 9'd0;
			cfg_q.prop_gain       <= 16'd640;
			cfg_q.deriv_gain      <= 16'd2816;
			cfg_q.imu_weight      <= 9'd0;
			cfg_q.wheel_deg_scale <= 16'hFF81;
			cfg_q.done_margin     <= 16'd200;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TARGET_HEADING:  cfg_q.target_heading  <= cfg_wdata[8:0];
				REG_PROP_GAIN:       cfg_q.prop_gain       <= cfg_wdata;
				REG_DERIV_GAIN:      cfg_q.deriv_gain      <= cfg_wdata;
				REG_IMU_WEIGHT:      cfg_q.imu_weight      <= cfg_wdata[8:0];
				REG_WHEEL_DEG_SCALE: cfg_q.wheel_deg_scale <= cfg_wdata;
				REG_DONE_MARGIN:     cfg_q.done_margin     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Capture the request while the sequencer is idle.
	assign s_tready = ctrl.idle;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			count_q <= s_tdata[31:0];
			imu_q   <= s_tdata[47:32];
			start_q <= s_tuser;
		end
	end

	assign status.in_valid = s_tvalid;
	assign status.out_busy = m_tvalid_q && !m_tready;
	assign status.no_pd    = no_pd;

	pdpt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	pdpt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (ctrl.op),
		.cfg         (cfg_q),
		.horiz_count (count_q),
		.imu_heading (imu_q),
		.start_req   (start_q),
		.no_pd       (no_pd),
		.drive       (drive),
		.finished    (finished)
	);

	assign right = -drive;

	// Result register; loaded by the output step once the previous result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT && !status.out_busy) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT && !status.out_busy) begin
			m_tdata_q <= {right, drive};
			m_tuser_q <= finished;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
